>>> src/fts_pkg.sv
// shared types and constants of the formula token scanner
// no dependencies; imported by every module of the block
package fts_pkg;

	// sequence limits and field widths
	localparam int MAX_SEQUENCE = 1024;
	localparam int POS_W        = $clog2(MAX_SEQUENCE);
	localparam int LEN_W        = POS_W + 1;
	localparam int CHAR_W       = 16;
	localparam int KIND_W       = 3;
	localparam int TOKEN_W      = KIND_W + POS_W + LEN_W;
	localparam int TDATA_OUT_W  = ((TOKEN_W + 7) / 8) * 8;

	// queue between front and back
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

	// token kinds
	localparam logic [KIND_W-1:0] KIND_PLUS    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_MINUS   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_TIMES   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DIVIDE  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_EQUALS  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_ELEMENT = 3'd5;
	localparam logic [KIND_W-1:0] KIND_NUMBER  = 3'd6;
	localparam logic [KIND_W-1:0] KIND_TEXT    = 3'd7;

	// character classes seen by the back end
	typedef enum logic [3:0] {
		CL_ELEM,
		CL_PLUS,
		CL_MINUS,
		CL_TIMES,
		CL_DIV,
		CL_EQ,
		CL_DIGIT,
		CL_DOT,
		CL_E,
		CL_LETTER,
		CL_OTHER
	} char_class_t;

	// one classified element in the queue
	typedef struct packed {
		char_class_t        cls;
		logic [POS_W-1:0]   pos;
		logic               last;
	} scan_item_t;

endpackage

>>> src/fts_front.sv
// front end: accepts element beats, classifies the character and tags its position
// depends on fts_pkg
module fts_front
	import fts_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CHAR_W-1:0] char_code,
	input  logic              last_element,
	input  logic              queue_full,
	output logic              push,
	output scan_item_t        push_item
);

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_SEQUENCE - 1);

	localparam logic [CHAR_W-1:0] CH_NUL    = 16'h0000;
	localparam logic [CHAR_W-1:0] CH_PLUS   = 16'h002B;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 16'h002D;
	localparam logic [CHAR_W-1:0] CH_TIMES  = 16'h002A;
	localparam logic [CHAR_W-1:0] CH_DIV    = 16'h002F;
	localparam logic [CHAR_W-1:0] CH_EQ     = 16'h003D;
	localparam logic [CHAR_W-1:0] CH_DOT    = 16'h002E;
	localparam logic [CHAR_W-1:0] CH_E      = 16'h0045;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 16'h0030;
	localparam logic [CHAR_W-1:0] CH_NINE   = 16'h0039;
	localparam logic [CHAR_W-1:0] CH_UP_A   = 16'h0041;
	localparam logic [CHAR_W-1:0] CH_UP_Z   = 16'h005A;
	localparam logic [CHAR_W-1:0] CH_LO_A   = 16'h0061;
	localparam logic [CHAR_W-1:0] CH_LO_Z   = 16'h007A;
	localparam logic [CHAR_W-1:0] CH_LATIN  = 16'h00FF;

	logic [POS_W-1:0] pos_q;
	char_class_t      cls;

	// character classification
	always_comb begin
		if (char_code == CH_NUL || char_code > CH_LATIN) begin
			cls = CL_ELEM;
		end else if (char_code == CH_PLUS) begin
			cls = CL_PLUS;
		end else if (char_code == CH_MINUS) begin
			cls = CL_MINUS;
		end else if (char_code == CH_TIMES) begin
			cls = CL_TIMES;
		end else if (char_code == CH_DIV) begin
			cls = CL_DIV;
		end else if (char_code == CH_EQ) begin
			cls = CL_EQ;
		end else if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
			cls = CL_DIGIT;
		end else if (char_code == CH_DOT) begin
			cls = CL_DOT;
		end else if (char_code == CH_E) begin
			cls = CL_E;
		end else if ((char_code >= CH_UP_A && char_code <= CH_UP_Z) ||
				(char_code >= CH_LO_A && char_code <= CH_LO_Z)) begin
			cls = CL_LETTER;
		end else begin
			cls = CL_OTHER;
		end
	end

	// handshake into the queue
	assign in_ready       = !queue_full;
	assign push           = in_valid && in_ready;
	assign push_item.cls  = cls;
	assign push_item.pos  = pos_q;
	assign push_item.last = last_element;

	// element position, wraps at the sequence limit and restarts after the last element
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			if (last_element || pos_q == POS_LAST) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

endmodule

>>> src/fts_queue.sv
// short queue of classified elements between front and back end
// depends on fts_pkg
module fts_queue
	import fts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  scan_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       not_empty,
	output scan_item_t head
);

	scan_item_t        slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full      = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = slots_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

>>> src/fts_back.sv
// back end: scan sequencer that builds tokens, backs off failed number continuations,
// and drives the token output register; depends on fts_pkg
module fts_back
	import fts_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  scan_item_t        item,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [KIND_W-1:0] token_kind,
	output logic [POS_W-1:0]  token_start,
	output logic [LEN_W-1:0]  token_length,
	output logic              last_token
);

	typedef enum logic [2:0] {
		M_IDLE,
		M_TEXT,
		M_INT,
		M_DOT,
		M_FRAC,
		M_EHELD,
		M_ESIGN,
		M_EXP
	} mode_t;

	typedef enum logic [1:0] {
		PH_CHAR,
		PH_SIGN,
		PH_END
	} phase_t;

	typedef enum logic [2:0] {
		ACT_GROW,
		ACT_HOLD_DOT,
		ACT_HOLD_E,
		ACT_CLOSE,
		ACT_OP,
		ACT_OPEN_INT,
		ACT_OPEN_TEXT
	} act_t;

	mode_t            mode_q, mode_d;
	phase_t           phase_q, phase_d;
	logic [POS_W-1:0] start_q, start_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic             sign_q, sign_d;
	logic             out_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [POS_W-1:0] tstart_q;
	logic [LEN_W-1:0] tlen_q;
	logic             tlast_q;

	logic             slot_free;
	logic             held_mode;
	logic [1:0]       held_k;
	char_class_t      scan_cls;
	logic             scan_last;
	logic [POS_W-1:0] scan_pos;
	logic             scan_letter;
	logic             scan_single;
	logic [KIND_W-1:0] op_kind;
	logic [KIND_W-1:0] close_kind;
	act_t             act;
	logic             done;
	logic             emit;
	logic [KIND_W-1:0] emit_kind;
	logic [POS_W-1:0] emit_start;
	logic [LEN_W-1:0] emit_len;
	logic             emit_last;

	// length grows with saturation at the sequence limit
	function automatic logic [LEN_W-1:0] sat_grow(input logic [LEN_W-1:0] len,
			input logic [1:0] amt);
		logic [LEN_W:0] sum;
		sum = {1'b0, len} + {{(LEN_W-1){1'b0}}, amt};
		if (sum > (LEN_W+1)'(MAX_SEQUENCE)) begin
			return LEN_W'(MAX_SEQUENCE);
		end
		return sum[LEN_W-1:0];
	endfunction

	assign slot_free  = !out_valid_q || out_ready;
	assign held_mode  = (mode_q == M_DOT) || (mode_q == M_EHELD) || (mode_q == M_ESIGN);
	assign held_k     = (mode_q == M_ESIGN) ? 2'd2 : 2'd1;
	assign close_kind = (mode_q == M_TEXT) ? KIND_TEXT : KIND_NUMBER;

	// the held sign is replayed as its own character after a failed exponent
	assign scan_cls  = (phase_q == PH_SIGN) ? (sign_q ? CL_MINUS : CL_PLUS) : item.cls;
	assign scan_last = (phase_q == PH_SIGN) ? 1'b0 : item.last;
	assign scan_pos  = (phase_q == PH_SIGN) ? item.pos - POS_W'(1) : item.pos;
	assign scan_letter = (scan_cls == CL_LETTER) || (scan_cls == CL_E);
	assign scan_single = (scan_cls == CL_ELEM) || (scan_cls == CL_PLUS) ||
		(scan_cls == CL_MINUS) || (scan_cls == CL_TIMES) ||
		(scan_cls == CL_DIV) || (scan_cls == CL_EQ);

	// kind of a single-element token
	always_comb begin
		case (scan_cls)
			CL_PLUS:  op_kind = KIND_PLUS;
			CL_MINUS: op_kind = KIND_MINUS;
			CL_TIMES: op_kind = KIND_TIMES;
			CL_DIV:   op_kind = KIND_DIVIDE;
			CL_EQ:    op_kind = KIND_EQUALS;
			default:  op_kind = KIND_ELEMENT;
		endcase
	end

	// what one scan step does in the current mode
	always_comb begin
		case (mode_q)
			M_IDLE: begin
				if (scan_single) begin
					act = ACT_OP;
				end else if (scan_cls == CL_DIGIT) begin
					act = ACT_OPEN_INT;
				end else begin
					act = ACT_OPEN_TEXT;
				end
			end
			M_TEXT: act = scan_letter ? ACT_GROW : ACT_CLOSE;
			M_INT: begin
				if (scan_cls == CL_DIGIT) begin
					act = ACT_GROW;
				end else if (scan_cls == CL_DOT && !scan_last) begin
					act = ACT_HOLD_DOT;
				end else if (scan_cls == CL_E && !scan_last) begin
					act = ACT_HOLD_E;
				end else begin
					act = ACT_CLOSE;
				end
			end
			M_FRAC: begin
				if (scan_cls == CL_DIGIT) begin
					act = ACT_GROW;
				end else if (scan_cls == CL_E && !scan_last) begin
					act = ACT_HOLD_E;
				end else begin
					act = ACT_CLOSE;
				end
			end
			M_EXP: act = (scan_cls == CL_DIGIT) ? ACT_GROW : ACT_CLOSE;
			default: act = ACT_CLOSE;
		endcase
	end

	// sequencer next state, one token at most per cycle
	always_comb begin
		mode_d     = mode_q;
		phase_d    = phase_q;
		start_d    = start_q;
		len_d      = len_q;
		sign_d     = sign_q;
		pop        = 1'b0;
		done       = 1'b0;
		emit       = 1'b0;
		emit_kind  = close_kind;
		emit_start = start_q;
		emit_len   = len_q;
		emit_last  = 1'b0;
		if (item_valid) begin
			case (phase_q)
				PH_END: begin
					// close the open token at the end of the sequence
					if (slot_free) begin
						emit      = 1'b1;
						emit_last = 1'b1;
						mode_d    = M_IDLE;
						phase_d   = PH_CHAR;
						start_d   = '0;
						len_d     = '0;
						pop       = 1'b1;
					end
				end
				PH_CHAR, PH_SIGN: begin
					if (phase_q == PH_CHAR && held_mode) begin
						if (mode_q == M_EHELD && !item.last &&
								(item.cls == CL_PLUS || item.cls == CL_MINUS)) begin
							// exponent sign joins the held part
							mode_d = M_ESIGN;
							sign_d = (item.cls == CL_MINUS);
							pop    = 1'b1;
						end else if (item.cls == CL_DIGIT) begin
							// held part joins the number
							len_d  = sat_grow(len_q, held_k + 2'd1);
							mode_d = (mode_q == M_DOT) ? M_FRAC : M_EXP;
							if (item.last) begin
								phase_d = PH_END;
							end else begin
								pop = 1'b1;
							end
						end else if (slot_free) begin
							// back off: number ends, held dot or E opens a text token
							emit      = 1'b1;
							emit_kind = KIND_NUMBER;
							mode_d    = M_TEXT;
							start_d   = item.pos - {{(POS_W-2){1'b0}}, held_k};
							len_d     = LEN_W'(1);
							phase_d   = (mode_q == M_ESIGN) ? PH_SIGN : PH_CHAR;
						end
					end else begin
						case (act)
							ACT_GROW: begin
								len_d = sat_grow(len_q, 2'd1);
								done  = 1'b1;
							end
							ACT_HOLD_DOT: begin
								mode_d = M_DOT;
								done   = 1'b1;
							end
							ACT_HOLD_E: begin
								mode_d = M_EHELD;
								done   = 1'b1;
							end
							ACT_CLOSE: begin
								if (slot_free) begin
									emit   = 1'b1;
									mode_d = M_IDLE;
									len_d  = '0;
								end
							end
							ACT_OP: begin
								if (slot_free) begin
									emit       = 1'b1;
									emit_kind  = op_kind;
									emit_start = scan_pos;
									emit_len   = LEN_W'(1);
									emit_last  = scan_last;
									done       = 1'b1;
								end
							end
							ACT_OPEN_INT: begin
								mode_d  = M_INT;
								start_d = scan_pos;
								len_d   = LEN_W'(1);
								done    = 1'b1;
							end
							ACT_OPEN_TEXT: begin
								mode_d  = M_TEXT;
								start_d = scan_pos;
								len_d   = LEN_W'(1);
								done    = 1'b1;
							end
							default: begin
								done = 1'b0;
							end
						endcase
						// finish the element or move to the next step
						if (done) begin
							if (phase_q == PH_SIGN) begin
								phase_d = PH_CHAR;
							end else if (scan_last) begin
								if (act == ACT_OP) begin
									start_d = '0;
									len_d   = '0;
									pop     = 1'b1;
								end else begin
									phase_d = PH_END;
								end
							end else begin
								pop = 1'b1;
							end
						end
					end
				end
				default: begin
					phase_d = PH_CHAR;
				end
			endcase
		end
	end

	// scan state and token output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_IDLE;
			phase_q     <= PH_CHAR;
			start_q     <= '0;
			len_q       <= '0;
			sign_q      <= 1'b0;
			out_valid_q <= 1'b0;
			kind_q      <= '0;
			tstart_q    <= '0;
			tlen_q      <= '0;
			tlast_q     <= 1'b0;
		end else begin
			mode_q  <= mode_d;
			phase_q <= phase_d;
			start_q <= start_d;
			len_q   <= len_d;
			sign_q  <= sign_d;
			if (emit) begin
				out_valid_q <= 1'b1;
				kind_q      <= emit_kind;
				tstart_q    <= emit_start;
				tlen_q      <= emit_len;
				tlast_q     <= emit_last;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign token_kind   = kind_q;
	assign token_start  = tstart_q;
	assign token_length = tlen_q;
	assign last_token   = tlast_q;

endmodule

>>> src/formula_token_scanner.sv
// formula token scanner top level: front end, element queue and scan back end
// depends on fts_pkg, fts_front, fts_queue, fts_back
//
// channel   direction  tdata (low bit up)                        tlast
// s_axis    in         char_code[15:0]                           last_element
// m_axis    out        token_kind[2:0] token_start[12:3]          last_token
//                      token_length[23:13]
//
// the back end takes each element in turn; it also spends extra steps on each
// token it emits before that element's own, on a token that the last element
// leaves open, and on a failed number continuation, more so for a held exponent
// sign.
// an element waits in the queue until the back end takes it; a token appears on
// m_axis in the cycle after it is built. asynchronous reset clears the position,
// scan state and queue. a stall on m_axis holds the back end only when it has a
// token to emit; the front keeps taking beats until the four-entry queue is full.
module formula_token_scanner
	import fts_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [CHAR_W-1:0]      s_axis_tdata,   // char_code
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // token_kind, token_start, token_length
	output logic                   m_axis_tlast
);

	logic              push;
	scan_item_t        push_item;
	logic              queue_full;
	logic              pop;
	logic              not_empty;
	scan_item_t        head;
	logic [KIND_W-1:0] token_kind;
	logic [POS_W-1:0]  token_start;
	logic [LEN_W-1:0]  token_length;

	// accept and classify
	fts_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.char_code    (s_axis_tdata),
		.last_element (s_axis_tlast),
		.queue_full   (queue_full),
		.push         (push),
		.push_item    (push_item)
	);

	// decoupling queue
	fts_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	// scan and emit tokens
	fts_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (not_empty),
		.item         (head),
		.pop          (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.last_token   (m_axis_tlast)
	);

	// output beat packing
	assign m_axis_tdata = TDATA_OUT_W'({token_length, token_start, token_kind});

endmodule

>>> sim/fts_token_checker.sv
`timescale 1ns / 100ps
// token checker for the formula token scanner: watches both stream channels,
// predicts the tokens of every accepted element and compares them in order
// depends on fts_pkg for field widths and token kinds
module fts_token_checker
	import fts_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [CHAR_W-1:0]      s_axis_tdata,
	input  logic                   s_axis_tlast,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [TDATA_OUT_W-1:0] m_axis_tdata,
	input  logic                   m_axis_tlast,
	output int                     mismatch_count,
	output int                     tokens_pending,
	output int                     tokens_checked
);

	localparam int REPORT_MAX = 10;
	localparam int STEP_MAX   = 5;

	// characters with a meaning of their own
	localparam logic [CHAR_W-1:0] CH_ELEMENT = 16'h0000;
	localparam logic [CHAR_W-1:0] CH_PLUS    = 16'h002B;
	localparam logic [CHAR_W-1:0] CH_MINUS   = 16'h002D;
	localparam logic [CHAR_W-1:0] CH_TIMES   = 16'h002A;
	localparam logic [CHAR_W-1:0] CH_DIVIDE  = 16'h002F;
	localparam logic [CHAR_W-1:0] CH_EQUALS  = 16'h003D;
	localparam logic [CHAR_W-1:0] CH_DOT     = 16'h002E;
	localparam logic [CHAR_W-1:0] CH_EXP     = 16'h0045;

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_TEXT,
		SCAN_INT,
		SCAN_DOT,
		SCAN_FRAC,
		SCAN_EHELD,
		SCAN_ESIGN,
		SCAN_EXP
	} scan_mode_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  start;
		logic [LEN_W-1:0]  len;
		logic              last;
	} token_t;

	// scanner state as the block should hold it
	scan_mode_t        mode_r;
	int                pos_r;
	int                tok_start;
	int                tok_len;
	logic [CHAR_W-1:0] held [2];
	logic [1:0]        held_cnt;

	token_t step_tokens[$];
	token_t tokens_due[$];
	int     n_bad;
	int     n_good;

	function automatic bit is_digit(input logic [CHAR_W-1:0] c);
		return c >= CHAR_W'("0") && c <= CHAR_W'("9");
	endfunction

	function automatic bit is_letter(input logic [CHAR_W-1:0] c);
		return (c >= CHAR_W'("A") && c <= CHAR_W'("Z")) ||
			(c >= CHAR_W'("a") && c <= CHAR_W'("z"));
	endfunction

	function automatic void clear_scan();
		mode_r = SCAN_IDLE;
		pos_r = 0;
		tok_start = 0;
		tok_len = 0;
		held[0] = '0;
		held[1] = '0;
		held_cnt = '0;
	endfunction

	function automatic void add_token(input logic [KIND_W-1:0] kind, input int start,
			input int len);
		token_t t;
		t.kind = kind;
		t.start = POS_W'(start);
		t.len = LEN_W'(len);
		t.last = 1'b0;
		if (step_tokens.size() < STEP_MAX)
			step_tokens.push_back(t);
	endfunction

	// token lengths saturate at the sequence limit
	function automatic void lengthen(input int k);
		tok_len = (tok_len + k > MAX_SEQUENCE) ? MAX_SEQUENCE : tok_len + k;
	endfunction

	function automatic void hold_char(input logic [CHAR_W-1:0] c, input scan_mode_t m);
		held[held_cnt[0]] = c;
		held_cnt = held_cnt + 2'd1;
		mode_r = m;
	endfunction

	function automatic void open_token(input scan_mode_t m, input int pos);
		mode_r = m;
		tok_start = pos;
		tok_len = 1;
	endfunction

	function automatic void close_token();
		if (mode_r == SCAN_TEXT)
			add_token(KIND_TEXT, tok_start, tok_len);
		else if (mode_r != SCAN_IDLE)
			add_token(KIND_NUMBER, tok_start, tok_len);
		mode_r = SCAN_IDLE;
		tok_len = 0;
	endfunction

	// one element in idle, text or digit modes
	function automatic void scan_char(input logic [CHAR_W-1:0] c, input int pos, input bit fin);
		bit dg;
		dg = is_digit(c);
		case (mode_r)
			SCAN_TEXT: begin
				if (is_letter(c)) begin
					lengthen(1);
					return;
				end
			end
			SCAN_INT: begin
				if (dg) begin
					lengthen(1);
					return;
				end
				if (c == CH_DOT && !fin) begin
					hold_char(c, SCAN_DOT);
					return;
				end
				if (c == CH_EXP && !fin) begin
					hold_char(c, SCAN_EHELD);
					return;
				end
			end
			SCAN_FRAC: begin
				if (dg) begin
					lengthen(1);
					return;
				end
				if (c == CH_EXP && !fin) begin
					hold_char(c, SCAN_EHELD);
					return;
				end
			end
			SCAN_EXP: begin
				if (dg) begin
					lengthen(1);
					return;
				end
			end
			default: ;
		endcase
		close_token();
		if (c == CH_ELEMENT || c > 16'd255)
			add_token(KIND_ELEMENT, pos, 1);
		else if (c == CH_PLUS)
			add_token(KIND_PLUS, pos, 1);
		else if (c == CH_MINUS)
			add_token(KIND_MINUS, pos, 1);
		else if (c == CH_TIMES)
			add_token(KIND_TIMES, pos, 1);
		else if (c == CH_DIVIDE)
			add_token(KIND_DIVIDE, pos, 1);
		else if (c == CH_EQUALS)
			add_token(KIND_EQUALS, pos, 1);
		else if (dg)
			open_token(SCAN_INT, pos);
		else
			open_token(SCAN_TEXT, pos);
	endfunction

	// tokens caused by one accepted element, queued in order
	function automatic void predict_tokens(input logic [CHAR_W-1:0] c, input bit fin);
		int pos;
		int k;
		int p;
		logic [CHAR_W-1:0] h0;
		logic [CHAR_W-1:0] h1;
		step_tokens.delete();
		pos = pos_r;
		if (mode_r == SCAN_DOT || mode_r == SCAN_EHELD || mode_r == SCAN_ESIGN) begin
			k = (held_cnt > 2'd2) ? 2 : int'(held_cnt);
			if (mode_r == SCAN_EHELD && (c == CH_PLUS || c == CH_MINUS) && !fin) begin
				hold_char(c, SCAN_ESIGN);
			end else if (is_digit(c)) begin
				// continuation confirmed: held elements join the number
				lengthen(k + 1);
				mode_r = (mode_r == SCAN_DOT) ? SCAN_FRAC : SCAN_EXP;
				held_cnt = '0;
			end else begin
				// continuation failed: number ends, held elements rescanned
				h0 = held[0];
				h1 = held[1];
				add_token(KIND_NUMBER, tok_start, tok_len);
				mode_r = SCAN_IDLE;
				tok_len = 0;
				held_cnt = '0;
				for (int j = 0; j < k; j++) begin
					p = (pos + MAX_SEQUENCE - k + j) % MAX_SEQUENCE;
					scan_char((j == 0) ? h0 : h1, p, 1'b0);
				end
				scan_char(c, pos, fin);
			end
		end else begin
			scan_char(c, pos, fin);
		end
		if (fin) begin
			close_token();
			if (step_tokens.size() > 0)
				step_tokens[step_tokens.size() - 1].last = 1'b1;
			clear_scan();
		end else begin
			pos_r = (pos + 1 >= MAX_SEQUENCE) ? 0 : pos + 1;
		end
		foreach (step_tokens[i])
			tokens_due.push_back(step_tokens[i]);
	endfunction

	function automatic void report_bad(input string what, input token_t want, input token_t got);
		n_bad++;
		if (n_bad <= REPORT_MAX) begin
			$display("%t %s: expected kind %0d start %0d len %0d last %0d",
				$realtime, what, want.kind, want.start, want.len, want.last);
			$display("    got kind %0d start %0d len %0d last %0d",
				got.kind, got.start, got.len, got.last);
		end
	endfunction

	// predict on element beats, compare on token beats
	always @(posedge clk or negedge arst_n) begin
		token_t got;
		token_t want;
		if (!arst_n) begin
			clear_scan();
			tokens_due.delete();
			n_bad = 0;
			n_good = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predict_tokens(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind = m_axis_tdata[KIND_W-1:0];
				got.start = m_axis_tdata[KIND_W +: POS_W];
				got.len = m_axis_tdata[KIND_W + POS_W +: LEN_W];
				got.last = m_axis_tlast;
				if (tokens_due.size() == 0) begin
					report_bad("token with none expected", '0, got);
				end else begin
					want = tokens_due.pop_front();
					if (got.kind !== want.kind || got.start !== want.start ||
							got.len !== want.len || got.last !== want.last)
						report_bad("token mismatch", want, got);
					else
						n_good++;
				end
			end
		end
		mismatch_count <= n_bad;
		tokens_pending <= tokens_due.size();
		tokens_checked <= n_good;
	end

endmodule

>>> sim/formula_token_scanner_tb.sv
`timescale 1ns / 100ps
// testbench top for the formula token scanner: element stimulus, token sink,
// watchdog and verdict; depends on fts_pkg, formula_token_scanner, fts_token_checker
module formula_token_scanner_tb;
	import fts_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 20;
	localparam int PHASE_ITEMS = 65;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [CHAR_W-1:0]      s_axis_tdata = '0;
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;

	int mismatch_count;
	int tokens_pending;
	int tokens_checked;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int items_sent = 0;
	int seqs_sent = 0;
	int quiet_cycles = 0;
	logic [CHAR_W-1:0] seq_chars[$];

	// idle mixes: none, sender idle, receiver stall, both
	int src_mix[4]  = '{0, 70, 0, 35};
	int sink_mix[4] = '{0, 0, 70, 35};

	formula_token_scanner dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	fts_token_checker token_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tlast   (s_axis_tlast),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tlast   (m_axis_tlast),
		.mismatch_count (mismatch_count),
		.tokens_pending (tokens_pending),
		.tokens_checked (tokens_checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// token sink with random stalls
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// cycles without any beat on either channel
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("FAILURE");
		$finish;
	end

	function automatic logic [CHAR_W-1:0] random_digit();
		return CHAR_W'("0") + CHAR_W'($urandom_range(0, 9));
	endfunction

	function automatic logic [CHAR_W-1:0] random_letter();
		logic [CHAR_W-1:0] base;
		base = $urandom_range(0, 1) ? CHAR_W'("a") : CHAR_W'("A");
		return base + CHAR_W'($urandom_range(0, 25));
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			seq_chars.push_back(CHAR_W'(s[i]));
	endtask

	// digits with optional fraction and exponent, often cut short
	task automatic add_number();
		string signs;
		signs = "+-";
		repeat ($urandom_range(1, 3)) seq_chars.push_back(random_digit());
		if ($urandom_range(0, 1)) begin
			seq_chars.push_back(CHAR_W'("."));
			if ($urandom_range(0, 4) != 0)
				repeat ($urandom_range(1, 2)) seq_chars.push_back(random_digit());
		end
		if ($urandom_range(0, 2) == 0) begin
			seq_chars.push_back(CHAR_W'("E"));
			if ($urandom_range(0, 1))
				seq_chars.push_back(CHAR_W'(signs[$urandom_range(0, 1)]));
			if ($urandom_range(0, 4) != 0)
				repeat ($urandom_range(1, 2)) seq_chars.push_back(random_digit());
		end
	endtask

	task automatic add_random_token();
		int roll;
		string ops;
		string punct;
		roll = $urandom_range(0, 99);
		ops = "+-*/=";
		punct = "(), #;.E";
		if (roll < 40) begin
			add_number();
		end else if (roll < 55) begin
			seq_chars.push_back(CHAR_W'(ops[$urandom_range(0, 4)]));
		end else if (roll < 63) begin
			seq_chars.push_back(($urandom_range(0, 3) == 0) ? 16'h0000 :
				CHAR_W'($urandom_range(256, 65535)));
		end else if (roll < 78) begin
			// text: a letter or stray character, then letters
			if ($urandom_range(0, 1))
				seq_chars.push_back(random_letter());
			else
				seq_chars.push_back(CHAR_W'(punct[$urandom_range(0, punct.len() - 1)]));
			repeat ($urandom_range(0, 4)) seq_chars.push_back(random_letter());
		end else if (roll < 85) begin
			seq_chars.push_back(CHAR_W'($urandom_range(128, 255)));
		end else if (roll < 92) begin
			seq_chars.push_back(CHAR_W'($urandom_range(0, 65535)));
		end else begin
			seq_chars.push_back(CHAR_W'($urandom_range(1, 127)));
		end
	endtask

	// one element beat; entered and left at a falling edge
	task automatic send_item(input logic [CHAR_W-1:0] code, input logic fin);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= code;
		s_axis_tlast <= fin;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_sequence();
		foreach (seq_chars[i])
			send_item(seq_chars[i], i == seq_chars.size() - 1);
		seq_chars.delete();
		seqs_sent++;
	endtask

	// sender holds off until every predicted token is out
	task automatic drain_tokens();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (tokens_pending != 0) @(negedge clk);
	endtask

	initial begin
		int phase_items;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// operators, embedded elements, latin-1 text start
		add_text("+-*/=");
		seq_chars.push_back(16'h0000);
		seq_chars.push_back(16'hFFFF);
		seq_chars.push_back(16'h00E9);
		add_text("b");
		send_sequence();
		// full number, failed continuations, held element at the end
		add_text("12.5E+3");
		send_sequence();
		add_text("1.Ez");
		send_sequence();
		add_text("9E-q");
		send_sequence();
		add_text("3.");
		send_sequence();
		add_text("6E+");
		send_sequence();
		drain_tokens();

		// random sequences under each idle mix
		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct = src_mix[ph];
			sink_stall_pct = sink_mix[ph];
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				repeat ($urandom_range(1, 6)) add_random_token();
				phase_items += seq_chars.size();
				send_sequence();
			end
			drain_tokens();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		$display("covered %0d sequences, %0d element beats, %0d tokens matched",
			seqs_sent, items_sent, tokens_checked);
		$display("directed corner cases and four sender/receiver idle mixes");
		if (mismatch_count == 0 && tokens_pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
